// ===== hdl/ping_rtt_window_tracker_core_macros.svh =====
// Assertion macros shared by the RTL of the round-trip-time tracker.
// No dependencies; include by bare file name inside a module body.
`ifndef PING_RTT_WINDOW_TRACKER_CORE_MACROS_SVH
`define PING_RTT_WINDOW_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PTR_CHECK_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ping_rtt_window_tracker_core: check failed");

// Next-cycle implication, checked out of reset.
`define PTR_CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ping_rtt_window_tracker_core: check failed");

`endif

// ===== hdl/ptr_pkg.sv =====
// Shared widths, constants and controller/datapath command and status types
// for the round-trip-time tracker. No dependencies.
`default_nettype none

package ptr_pkg;

  localparam int STAMP_W = 64;
  localparam int AGE_W   = 32;
  localparam int RTT_W   = 32;
  localparam int SUM_W   = 39;
  localparam int COUNT_W = 8;

  localparam logic [AGE_W-1:0] AGE_RESET = 32'd3000000;

  localparam logic KIND_PING = 1'b0;
  localparam logic KIND_PONG = 1'b1;

  typedef struct packed {
    logic capture;
    logic drop_head;
    logic append;
    logic scan_clr;
    logic scan_inc;
    logic remove_at;
    logic win_write;
    logic win_read;
    logic load_out;
  } ptr_cmd_t;

  typedef struct packed {
    logic is_pong;
    logic q_empty;
    logic q_full;
    logic head_aged;
    logic scan_end;
    logic scan_hit;
    logic rtt_ok;
    logic rd_last;
    logic out_free;
  } ptr_sts_t;

endpackage

`default_nettype wire

// ===== hdl/ptr_ifs.sv =====
// Valid/ready channel interfaces of the round-trip-time tracker.
// Depends on ptr_pkg for the field widths.
`default_nettype none

interface ptr_stamp_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ptr_pkg::STAMP_W-1:0]  now_us;
  logic [ptr_pkg::STAMP_W-1:0]  echoed_us;
  modport source (output valid, kind, now_us, echoed_us, input ready);
  modport sink   (input valid, kind, now_us, echoed_us, output ready);
endinterface

interface ptr_report_if;
  logic                         valid;
  logic                         ready;
  logic [ptr_pkg::RTT_W-1:0]    rtt_us;
  logic [ptr_pkg::SUM_W-1:0]    window_sum;
  logic [ptr_pkg::RTT_W-1:0]    window_min;
  logic [ptr_pkg::RTT_W-1:0]    window_max;
  logic [ptr_pkg::COUNT_W-1:0]  window_count;
  modport source (output valid, rtt_us, window_sum, window_min, window_max, window_count,
                  input ready);
  modport sink   (input valid, rtt_us, window_sum, window_min, window_max, window_count,
                  output ready);
endinterface

interface ptr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ptr_pkg::AGE_W-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ptr_ctrl.sv =====
// Controller state machine of the round-trip-time tracker.
// Depends on ptr_pkg; drives datapath commands from its status.
`default_nettype none

module ptr_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               item_valid,
  output logic              item_ready,
  input  ptr_pkg::ptr_sts_t sts,
  output ptr_pkg::ptr_cmd_t cmd
);
  import ptr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_APPEND,
    S_SCAN,
    S_WRITE,
    S_WALK,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_AGE;
        end
      end
      S_AGE: begin
        // drop one expired head per cycle, then branch on item kind
        if (!sts.q_empty && sts.head_aged) begin
          cmd.drop_head = 1'b1;
        end else if (!sts.is_pong) begin
          if (sts.q_full) begin
            cmd.drop_head = 1'b1;
            state_next    = S_APPEND;
          end else begin
            cmd.append = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_IDLE;
        end else if (sts.scan_hit) begin
          cmd.remove_at = 1'b1;
          state_next    = sts.rtt_ok ? S_WRITE : S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.win_write = 1'b1;
        state_next    = S_WALK;
      end
      S_WALK: begin
        cmd.win_read = 1'b1;
        if (sts.rd_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ptr_dpath.sv =====
// Datapath of the round-trip-time tracker: pending-ping queue, sample window
// memory, window walk accumulators and result register. Depends on ptr_pkg, ptr_ifs.
`default_nettype none

module ptr_dpath #(
  parameter int PENDING_DEPTH = 16,
  parameter int WINDOW_DEPTH  = 128
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            kind,
  input  wire [ptr_pkg::STAMP_W-1:0]     now_us,
  input  wire [ptr_pkg::STAMP_W-1:0]     echoed_us,
  input  ptr_pkg::ptr_cmd_t              cmd,
  output ptr_pkg::ptr_sts_t              sts,
  ptr_cfg_if.sink                        cfg,
  ptr_report_if.source                   report
);
  import ptr_pkg::*;

  localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);

  // captured item
  logic               kind_q;
  logic [STAMP_W-1:0] now_q;
  logic [STAMP_W-1:0] echo_q;

  logic [AGE_W-1:0]   age;

  // pending queue, oldest at entry 0
  logic [STAMP_W-1:0] q [PENDING_DEPTH];
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      shift_base;

  // window
  logic [RTT_W-1:0]   win_mem [WINDOW_DEPTH];
  logic [AW-1:0]      head;
  logic [FW-1:0]      fill;
  logic [AW-1:0]      rd_addr;
  logic               rd_pend;
  logic [RTT_W-1:0]   rd_data;
  logic [SUM_W-1:0]   sum;
  logic [RTT_W-1:0]   mn;
  logic [RTT_W-1:0]   mx;
  logic [FW+7:0]      fill_wide;

  logic [STAMP_W-1:0] rtt_full;
  logic [STAMP_W-1:0] head_age;
  logic [STAMP_W-1:0] age_wide;

  // result register
  logic               out_valid;
  logic [RTT_W-1:0]   out_rtt;
  logic [SUM_W-1:0]   out_sum;
  logic [RTT_W-1:0]   out_min;
  logic [RTT_W-1:0]   out_max;
  logic [COUNT_W-1:0] out_count;

  assign age_wide   = {{(STAMP_W-AGE_W){1'b0}}, age};
  assign rtt_full   = now_q - echo_q;
  assign head_age   = now_q - q[0];
  assign shift_base = cmd.drop_head ? '0 : idx;
  assign fill_wide  = {8'b0, fill};

  always_comb begin
    sts           = '0;
    sts.is_pong   = (kind_q == KIND_PONG);
    sts.q_empty   = (cnt == '0);
    sts.q_full    = (cnt == CW'(PENDING_DEPTH));
    sts.head_aged = (head_age > age_wide);
    sts.scan_end  = (idx == cnt);
    sts.scan_hit  = (q[idx[IW-1:0]] == echo_q);
    sts.rtt_ok    = (rtt_full != '0) && (rtt_full < age_wide);
    sts.rd_last   = (FW'(rd_addr) == (fill - FW'(1)));
    sts.out_free  = !out_valid || report.ready;
  end

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= AGE_RESET;
    end else if (cfg.valid) begin
      age <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      now_q  <= now_us;
      echo_q <= echoed_us;
    end
  end

  // queue storage: shift down from shift_base on drop/remove
  always_ff @(posedge clk) begin
    if (cmd.drop_head || cmd.remove_at) begin
      for (int j = 0; j < PENDING_DEPTH - 1; j++) begin
        if (CW'(j) >= shift_base) begin
          q[j] <= q[j+1];
        end
      end
    end else if (cmd.append) begin
      q[cnt[IW-1:0]] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else begin
      if (cmd.drop_head || cmd.remove_at) begin
        cnt <= cnt - CW'(1);
      end else if (cmd.append) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.scan_clr) begin
        idx <= '0;
      end else if (cmd.scan_inc) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (cmd.win_write) begin
      win_mem[head] <= rtt_full[RTT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      fill    <= '0;
      rd_addr <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.win_read;
      if (cmd.win_write) begin
        head    <= (head == AW'(WINDOW_DEPTH - 1)) ? '0 : head + AW'(1);
        rd_addr <= '0;
        if (fill != FW'(WINDOW_DEPTH)) begin
          fill <= fill + FW'(1);
        end
      end else if (cmd.win_read) begin
        rd_addr <= rd_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_write) begin
      sum <= '0;
      mn  <= rtt_full[RTT_W-1:0];
      mx  <= rtt_full[RTT_W-1:0];
    end else if (rd_pend) begin
      sum <= sum + SUM_W'(rd_data);
      if (rd_data < mn) begin
        mn <= rd_data;
      end
      if (rd_data > mx) begin
        mx <= rd_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rtt   <= rtt_full[RTT_W-1:0];
      out_sum   <= sum;
      out_min   <= mn;
      out_max   <= mx;
      out_count <= fill_wide[COUNT_W-1:0];
    end
  end

  assign report.valid        = out_valid;
  assign report.rtt_us       = out_rtt;
  assign report.window_sum   = out_sum;
  assign report.window_min   = out_min;
  assign report.window_max   = out_max;
  assign report.window_count = out_count;

endmodule

`default_nettype wire

// ===== hdl/ping_rtt_window_tracker_core.sv =====
// Round-trip-time tracker top level: one item at a time, input ready only when idle.
// Ping: drops aged entries, drops the oldest entry if the queue is full, then appends.
// Pong: drops aged entries, scans for the match, writes the window and walks its
// samples through the single memory read port before loading the result register.
// Unmatched pongs end after the scan; a result waits for report.ready in an output register.
// Synchronous active-high reset empties the queue and window and loads the 3 s age limit.
`default_nettype none

module ping_rtt_window_tracker_core #(
  parameter int PENDING_DEPTH = 16,
  parameter int WINDOW_DEPTH  = 128
) (
  input  wire          clk,
  input  wire          rst,
  ptr_stamp_if.sink    stamp,
  ptr_cfg_if.sink      cfg,
  ptr_report_if.source report
);
  import ptr_pkg::*;

  `include "ping_rtt_window_tracker_core_macros.svh"

  ptr_cmd_t cmd;
  ptr_sts_t sts;
  logic     item_ready;

  // hold off new items while one is in progress; results wait in the
  // datapath's output register so the next item may enter meanwhile
  assign stamp.ready = item_ready;

  ptr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (stamp.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // queue of outstanding ping stamps, window memory and result register
  ptr_dpath #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .WINDOW_DEPTH  (WINDOW_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .kind      (stamp.kind),
    .now_us    (stamp.now_us),
    .echoed_us (stamp.echoed_us),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .report    (report)
  );

  // one item in flight: input is closed in the cycle after an accept
  `PTR_CHECK_NEXT(a_single_item, clk, rst, stamp.valid && stamp.ready, !stamp.ready)
  // window extremes are ordered
  `PTR_CHECK_NOW(a_min_le_max, clk, rst, report.valid, report.window_min <= report.window_max)
  // reported rtt is nonzero and lies within the window extremes
  `PTR_CHECK_NOW(a_rtt_in_range, clk, rst, report.valid,
    report.rtt_us != '0 && report.rtt_us >= report.window_min &&
    report.rtt_us <= report.window_max)

endmodule

`default_nettype wire
